FILE: design/necdec_pkg.sv
// Shared types and constants of the NEC infrared frame decoder.
// Used by every module of the decoder; depends on nothing else.
`default_nettype none

package necdec_pkg;

   typedef enum logic [1:0] {
      KIND_MARK    = 2'd0,
      KIND_SPACE   = 2'd1,
      KIND_TIMEOUT = 2'd2,
      KIND_OTHER   = 2'd3
   } sample_kind_type;

   typedef enum logic [1:0] {
      RES_REJECT = 2'd0,
      RES_FULL   = 2'd1,
      RES_REPEAT = 2'd2
   } result_kind_type;

   typedef enum logic [2:0] {
      CSR_HEADER_MARK  = 3'd0,
      CSR_HEADER_SPACE = 3'd1,
      CSR_REPEAT_SPACE = 3'd2,
      CSR_UNIT         = 3'd3,
      CSR_ONE_SPACE    = 3'd4,
      CSR_LEAD_TOL     = 3'd5,
      CSR_BIT_TOL      = 3'd6,
      CSR_END_SPACE    = 3'd7
   } csr_index_type;

   localparam int NUM_REFS = 5;
   localparam int REF_HM   = 0;
   localparam int REF_HS   = 1;
   localparam int REF_RS   = 2;
   localparam int REF_UNIT = 3;
   localparam int REF_ONE  = 4;

   localparam logic [15:0] HEADER_MARK_RESET  = 16'd9000;
   localparam logic [15:0] HEADER_SPACE_RESET = 16'd4500;
   localparam logic [15:0] REPEAT_SPACE_RESET = 16'd2250;
   localparam logic [15:0] UNIT_RESET         = 16'd562;
   localparam logic [15:0] ONE_SPACE_RESET    = 16'd1687;
   localparam logic [6:0]  LEAD_TOL_RESET     = 7'd35;
   localparam logic [6:0]  BIT_TOL_RESET      = 7'd45;
   localparam logic [23:0] END_SPACE_RESET    = 24'd10000;

   localparam int FULL_LEN   = 67;
   localparam int REPEAT_LEN = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [NUM_REFS-1:0][15:0] ref_us;
      logic [NUM_REFS-1:0][22:0] thr;
      logic [23:0]               end_space_us;
   } cfg_type;

   typedef struct packed {
      logic                is_end;
      logic                is_mark;
      logic [NUM_REFS-1:0] near;
   } token_type;

endpackage

`default_nettype wire

FILE: design/necdec_csr.sv
// Configuration registers and the tolerance thresholds derived from them.
// Depends on necdec_pkg.
`default_nettype none

module necdec_csr
   import necdec_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_data,
   output cfg_type          cfg
);

   logic [NUM_REFS-1:0][15:0] ref_ff, ref_in;
   logic [NUM_REFS-1:0][22:0] thr_ff, thr_in;
   logic [6:0]  lead_tol_ff, lead_tol_in;
   logic [6:0]  bit_tol_ff, bit_tol_in;
   logic [23:0] end_space_ff, end_space_in;

   assign csr_ready = 1'b1;

   always_comb begin
      logic [6:0]  tol;
      logic [15:0] base;
      ref_in       = ref_ff;
      lead_tol_in  = lead_tol_ff;
      bit_tol_in   = bit_tol_ff;
      end_space_in = end_space_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_HEADER_MARK: begin
               ref_in[REF_HM] = csr_data[15:0];
            end
            CSR_HEADER_SPACE: begin
               ref_in[REF_HS] = csr_data[15:0];
            end
            CSR_REPEAT_SPACE: begin
               ref_in[REF_RS] = csr_data[15:0];
            end
            CSR_UNIT: begin
               ref_in[REF_UNIT] = csr_data[15:0];
            end
            CSR_ONE_SPACE: begin
               ref_in[REF_ONE] = csr_data[15:0];
            end
            CSR_LEAD_TOL: begin
               lead_tol_in = csr_data[6:0];
            end
            CSR_BIT_TOL: begin
               bit_tol_in = csr_data[6:0];
            end
            CSR_END_SPACE: begin
               end_space_in = csr_data;
            end
            default: begin
            end
         endcase
      end
      for (int r = 0; r < NUM_REFS; r++) begin
         tol  = (r == REF_HM || r == REF_HS || r == REF_RS) ? lead_tol_ff : bit_tol_ff;
         base = (ref_ff[r] == 16'd0) ? 16'd1 : ref_ff[r];
         thr_in[r] = 23'(tol) * 23'(base);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff[REF_HM]   <= HEADER_MARK_RESET;
         ref_ff[REF_HS]   <= HEADER_SPACE_RESET;
         ref_ff[REF_RS]   <= REPEAT_SPACE_RESET;
         ref_ff[REF_UNIT] <= UNIT_RESET;
         ref_ff[REF_ONE]  <= ONE_SPACE_RESET;
         lead_tol_ff      <= LEAD_TOL_RESET;
         bit_tol_ff       <= BIT_TOL_RESET;
         end_space_ff     <= END_SPACE_RESET;
      end else begin
         ref_ff       <= ref_in;
         lead_tol_ff  <= lead_tol_in;
         bit_tol_ff   <= bit_tol_in;
         end_space_ff <= end_space_in;
      end
   end

   always_ff @(posedge clock) begin
      thr_ff <= thr_in;
   end

   assign cfg.ref_us       = ref_ff;
   assign cfg.thr          = thr_ff;
   assign cfg.end_space_us = end_space_ff;

endmodule

`default_nettype wire

FILE: design/necdec_front.sv
// Front end: accepts samples, drops ignored kinds and classifies each
// sample against the nominal lengths. Depends on necdec_pkg.
`default_nettype none

module necdec_front
   import necdec_pkg::*;
#(
   parameter int DURATION_WIDTH = 24
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [1:0]                req_type,
   input  wire logic [DURATION_WIDTH-1:0] req_duration,
   input  wire cfg_type                   cfg,
   input  wire logic                      queue_full,
   output logic                           push,
   output token_type                      push_token
);

   logic                      va_ff, va_in;
   sample_kind_type           kind_ff;
   logic [DURATION_WIDTH-1:0] dur_ff;

   logic                      vb_ff, vb_in;
   logic                      end_ff, end_in;
   logic                      mark_ff, mark_in;
   logic [NUM_REFS-1:0][16:0] diff_ff, diff_in;
   logic [NUM_REFS-1:0]       big_ff, big_in;

   logic a_adv;
   logic b_free;
   logic accept;

   assign b_free    = !vb_ff || !queue_full;
   assign a_adv     = !va_ff || b_free;
   assign req_stall = !a_adv;
   assign accept    = req_valid && a_adv;

   always_comb begin
      logic [32:0] d33;
      logic [32:0] e33;
      logic [32:0] diff;
      va_in = va_ff;
      vb_in = vb_ff;
      if (a_adv) begin
         va_in = accept && (sample_kind_type'(req_type) != KIND_OTHER);
      end
      if (b_free) begin
         vb_in = va_ff;
      end
      d33     = 33'(dur_ff);
      end_in  = (kind_ff == KIND_TIMEOUT) ||
                ((kind_ff == KIND_SPACE) && (d33 >= 33'(cfg.end_space_us)));
      mark_in = (kind_ff == KIND_MARK);
      for (int r = 0; r < NUM_REFS; r++) begin
         e33        = 33'(cfg.ref_us[r]);
         diff       = (d33 >= e33) ? (d33 - e33) : (e33 - d33);
         diff_in[r] = diff[16:0];
         big_in[r]  = |diff[32:17];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         kind_ff <= sample_kind_type'(req_type);
         dur_ff  <= req_duration;
      end
      if (b_free) begin
         end_ff  <= end_in;
         mark_ff <= mark_in;
         diff_ff <= diff_in;
         big_ff  <= big_in;
      end
   end

   always_comb begin
      logic [23:0] prod;
      push_token.is_end  = end_ff;
      push_token.is_mark = mark_ff;
      for (int r = 0; r < NUM_REFS; r++) begin
         prod = (24'(diff_ff[r]) << 6) + (24'(diff_ff[r]) << 5) + (24'(diff_ff[r]) << 2);
         push_token.near[r] = !big_ff[r] && (prod <= 24'(cfg.thr[r]));
      end
   end

   assign push = vb_ff && !queue_full;

endmodule

`default_nettype wire

FILE: design/necdec_queue.sv
// Short queue of classified samples between the front end and the frame
// engine. Depends on necdec_pkg.
`default_nettype none

module necdec_queue
   import necdec_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire token_type push_token,
   output logic           full,
   input  wire logic      pop,
   output logic           tok_valid,
   output token_type      tok
);

   token_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign tok_valid = (count_ff != '0);
   assign tok       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

`default_nettype wire

FILE: design/necdec_back.sv
// Frame engine: tracks the current frame element by element and registers
// one classified result per ended frame. Depends on necdec_pkg.
`default_nettype none

module necdec_back
   import necdec_pkg::*;
#(
   parameter int MAX_ELEMENTS = 300
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      tok_valid,
   input  wire token_type tok,
   output logic           tok_pop,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output logic [1:0]     rsp_result_kind,
   output logic [7:0]     rsp_address,
   output logic [7:0]     rsp_command
);

   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             expect_mark_ff, expect_mark_in;
   logic [31:0]      data_ff, data_in;
   logic             full_ok_ff, full_ok_in;
   logic             repeat_ok_ff, repeat_ok_in;

   logic             rsp_valid_ff, rsp_valid_in;
   result_kind_type  kind_ff, kind_in;
   logic [7:0]       addr_ff, addr_in;
   logic [7:0]       cmd_ff, cmd_in;

   logic             out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign tok_pop  = tok_valid && (!tok.is_end || out_free);

   always_comb begin
      logic             mismatch;
      logic [CNT_W-1:0] i;
      logic [CNT_W-1:0] i_m3;
      logic [4:0]       bit_idx;
      logic [7:0]       b0, b1, b2, b3;
      mismatch = !tok.is_end && (tok.is_mark != expect_mark_ff);
      i        = mismatch ? '0 : count_ff;
      i_m3     = i - CNT_W'(3);
      bit_idx  = i_m3[5:1];
      b0       = data_ff[7:0];
      b1       = data_ff[15:8];
      b2       = data_ff[23:16];
      b3       = data_ff[31:24];

      count_in       = count_ff;
      expect_mark_in = expect_mark_ff;
      data_in        = data_ff;
      full_ok_in     = full_ok_ff;
      repeat_ok_in   = repeat_ok_ff;
      rsp_valid_in   = rsp_valid_ff && !out_free;
      kind_in        = kind_ff;
      addr_in        = addr_ff;
      cmd_in         = cmd_ff;

      if (tok_pop) begin
         if (tok.is_end) begin
            if (count_ff != '0) begin
               rsp_valid_in = 1'b1;
               kind_in      = RES_REJECT;
               addr_in      = 8'd0;
               cmd_in       = 8'd0;
               if (count_ff == CNT_W'(REPEAT_LEN) && repeat_ok_ff) begin
                  kind_in = RES_REPEAT;
               end else if (count_ff == CNT_W'(FULL_LEN) && full_ok_ff &&
                            b1 == ~b0 && b3 == ~b2) begin
                  kind_in = RES_FULL;
                  addr_in = b0;
                  cmd_in  = b2;
               end
            end
            count_in       = '0;
            data_in        = '0;
            full_ok_in     = 1'b1;
            repeat_ok_in   = 1'b1;
            expect_mark_in = 1'b1;
         end else begin
            if (mismatch) begin
               count_in       = '0;
               data_in        = '0;
               full_ok_in     = 1'b1;
               repeat_ok_in   = 1'b1;
               expect_mark_in = 1'b1;
            end
            if (!mismatch || tok.is_mark) begin
               if (i == '0) begin
                  if (!tok.near[REF_HM]) begin
                     full_ok_in   = 1'b0;
                     repeat_ok_in = 1'b0;
                  end
               end else if (i == CNT_W'(1)) begin
                  if (!tok.near[REF_HS]) begin
                     full_ok_in = 1'b0;
                  end
                  if (!tok.near[REF_RS]) begin
                     repeat_ok_in = 1'b0;
                  end
               end else if (i < CNT_W'(FULL_LEN)) begin
                  if (!i[0]) begin
                     if (!tok.near[REF_UNIT]) begin
                        full_ok_in = 1'b0;
                        if (i == CNT_W'(2)) begin
                           repeat_ok_in = 1'b0;
                        end
                     end
                  end else if (tok.near[REF_ONE]) begin
                     data_in[bit_idx] = 1'b1;
                  end else if (!tok.near[REF_UNIT]) begin
                     full_ok_in = 1'b0;
                  end
               end
               count_in       = CNT_W'(i + 1'b1);
               expect_mark_in = !tok.is_mark;
               if (i == CNT_W'(MAX_ELEMENTS)) begin
                  count_in       = '0;
                  data_in        = '0;
                  full_ok_in     = 1'b1;
                  repeat_ok_in   = 1'b1;
                  expect_mark_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         expect_mark_ff <= 1'b1;
         data_ff        <= '0;
         full_ok_ff     <= 1'b1;
         repeat_ok_ff   <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         count_ff       <= count_in;
         expect_mark_ff <= expect_mark_in;
         data_ff        <= data_in;
         full_ok_ff     <= full_ok_in;
         repeat_ok_ff   <= repeat_ok_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      addr_ff <= addr_in;
      cmd_ff  <= cmd_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_address     = addr_ff;
   assign rsp_command     = cmd_ff;

   // A frame never holds more elements than the configured maximum.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ELEMENTS))
      else $error("element count above maximum");

   // Address and command are zero unless a full frame was decoded.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (kind_ff != RES_FULL) |-> (addr_ff == 8'd0) && (cmd_ff == 8'd0))
      else $error("nonzero payload on non-full result");

   // A new result appears only after a frame end was taken from the queue.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(tok_pop && tok.is_end))
      else $error("result without frame end");

   // Marks and spaces never wait on the result register.
   assert property (@(posedge clock) disable iff (reset)
      tok_valid && !tok.is_end |-> tok_pop)
      else $error("element request held back");

endmodule

`default_nettype wire

FILE: design/nec_ir_frame_decoder_core.sv
// Top level of the NEC infrared frame decoder: configuration registers,
// front end, request queue and frame engine. Depends on necdec_pkg.
//
//   Channel   Direction  Handshake             Payload
//   req       in         req_valid/req_stall   req_type, req_duration
//   rsp       out        rsp_valid/rsp_stall   rsp_result_kind, rsp_address, rsp_command
//   csr       in         csr_valid/csr_ready   csr_index, csr_data
//
// One request is taken per cycle while req_stall is low; a result is registered once the
// request that ends its frame has passed the two front stages and the queue.
// Reset is synchronous; it resets control and configuration registers, not data registers.
// Only frame-ending requests wait on a stalled result; the four-entry queue absorbs the
// requests behind them until it fills. The csr port is always ready.
`default_nettype none

module nec_ir_frame_decoder_core
   import necdec_pkg::*;
#(
   parameter int MAX_ELEMENTS   = 300,
   parameter int DURATION_WIDTH = 24
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [1:0]                req_type,
   input  wire logic [DURATION_WIDTH-1:0] req_duration,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [1:0]                     rsp_result_kind,
   output logic [7:0]                     rsp_address,
   output logic [7:0]                     rsp_command,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [2:0]                csr_index,
   input  wire logic [23:0]               csr_data
);

   cfg_type   cfg;
   logic      queue_full;
   logic      push;
   token_type push_token;
   logic      tok_valid;
   token_type tok;
   logic      tok_pop;

   necdec_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   necdec_front #(
      .DURATION_WIDTH (DURATION_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_duration (req_duration),
      .cfg          (cfg),
      .queue_full   (queue_full),
      .push         (push),
      .push_token   (push_token)
   );

   necdec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .full       (queue_full),
      .pop        (tok_pop),
      .tok_valid  (tok_valid),
      .tok        (tok)
   );

   necdec_back #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .tok_valid       (tok_valid),
      .tok             (tok),
      .tok_pop         (tok_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_address     (rsp_address),
      .rsp_command     (rsp_command)
   );

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the NEC infrared frame decoder core.
// Drives random and directed receiver samples, predicts every frame result and checks it.
// Depends on necdec_pkg and nec_ir_frame_decoder_core.
`timescale 1ns / 100ps

module tb;
   import necdec_pkg::*;

   localparam int MAX_ELEMENTS  = 300;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 10;

   typedef struct {
      sample_kind_type kind;
      logic [23:0]     dur;
   } ir_sample_type;

   typedef struct {
      result_kind_type kind;
      logic [7:0]      addr;
      logic [7:0]      cmd;
   } frame_result_type;

   class frame_scoreboard;
      logic [15:0]      hdr_mark, hdr_space, rpt_space, unit_len, one_len;
      logic [6:0]       lead_tol, bit_tol;
      logic [23:0]      end_len;
      int unsigned      elem_count;
      bit               want_mark, full_ok, rpt_ok;
      logic [31:0]      data_bits;
      frame_result_type pending_frames[$];
      int unsigned      errors;

      function new();
         hdr_mark = HEADER_MARK_RESET;
         hdr_space = HEADER_SPACE_RESET;
         rpt_space = REPEAT_SPACE_RESET;
         unit_len = UNIT_RESET;
         one_len = ONE_SPACE_RESET;
         lead_tol = LEAD_TOL_RESET;
         bit_tol = BIT_TOL_RESET;
         end_len = END_SPACE_RESET;
         errors = 0;
         clear_frame();
      endfunction

      function void set_reg(csr_index_type idx, logic [23:0] data);
         case (idx)
            CSR_HEADER_MARK:  hdr_mark = data[15:0];
            CSR_HEADER_SPACE: hdr_space = data[15:0];
            CSR_REPEAT_SPACE: rpt_space = data[15:0];
            CSR_UNIT:         unit_len = data[15:0];
            CSR_ONE_SPACE:    one_len = data[15:0];
            CSR_LEAD_TOL:     lead_tol = data[6:0];
            CSR_BIT_TOL:      bit_tol = data[6:0];
            CSR_END_SPACE:    end_len = data;
            default:          ;
         endcase
      endfunction

      function int unsigned outstanding();
         return pending_frames.size();
      endfunction

      function void clear_frame();
         elem_count = 0;
         data_bits = '0;
         full_ok = 1'b1;
         rpt_ok = 1'b1;
         want_mark = 1'b1;
      endfunction

      function bit is_near(logic [23:0] d, logic [23:0] e, logic [6:0] tol);
         longint unsigned diff, base;
         diff = (d >= e) ? d - e : e - d;
         base = (e == 0) ? 1 : e;
         return diff * 100 <= tol * base;
      endfunction

      function void add_element(logic [23:0] d);
         int unsigned i;
         i = elem_count;
         if (i == 0) begin
            if (!is_near(d, hdr_mark, lead_tol)) begin
               full_ok = 1'b0;
               rpt_ok = 1'b0;
            end
         end else if (i == 1) begin
            if (!is_near(d, hdr_space, lead_tol))
               full_ok = 1'b0;
            if (!is_near(d, rpt_space, lead_tol))
               rpt_ok = 1'b0;
         end else if (i < FULL_LEN) begin
            if (i % 2 == 0) begin
               if (!is_near(d, unit_len, bit_tol)) begin
                  full_ok = 1'b0;
                  if (i == 2)
                     rpt_ok = 1'b0;
               end
            end else if (is_near(d, one_len, bit_tol)) begin
               data_bits[(i - 3) / 2] = 1'b1;
            end else if (!is_near(d, unit_len, bit_tol)) begin
               full_ok = 1'b0;
            end
         end
         elem_count = i + 1;
         want_mark = !want_mark;
         if (elem_count > MAX_ELEMENTS)
            clear_frame();
      endfunction

      function frame_result_type classify();
         frame_result_type r;
         r = '{RES_REJECT, 8'h00, 8'h00};
         if (elem_count == REPEAT_LEN && rpt_ok) begin
            r.kind = RES_REPEAT;
         end else if (elem_count == FULL_LEN && full_ok &&
                      data_bits[15:8] == ~data_bits[7:0] &&
                      data_bits[31:24] == ~data_bits[23:16]) begin
            r.kind = RES_FULL;
            r.addr = data_bits[7:0];
            r.cmd = data_bits[23:16];
         end
         return r;
      endfunction

      function void note_sample(ir_sample_type s);
         bit               is_mark;
         frame_result_type res;
         if (s.kind == KIND_OTHER)
            return;
         if (s.kind == KIND_TIMEOUT || (s.kind == KIND_SPACE && s.dur >= end_len)) begin
            if (elem_count != 0) begin
               res = classify();
               pending_frames.insert(pending_frames.size(), res);
            end
            clear_frame();
            return;
         end
         is_mark = (s.kind == KIND_MARK);
         if (is_mark != want_mark) begin
            clear_frame();
            if (!is_mark)
               return;
         end
         add_element(s.dur);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 100)
            $display("tb: mismatch: %s", msg);
      endtask

      task check_frame(logic [1:0] kind, logic [7:0] addr, logic [7:0] cmd);
         frame_result_type want;
         if (pending_frames.size() == 0) begin
            report($sformatf("unexpected result kind %0d addr %02h cmd %02h", kind, addr, cmd));
            return;
         end
         want = pending_frames.pop_front();
         if (kind !== want.kind)
            report($sformatf("result kind %0d, predicted %0d", kind, want.kind));
         if (addr !== want.addr)
            report($sformatf("address %02h, predicted %02h", addr, want.addr));
         if (cmd !== want.cmd)
            report($sformatf("command %02h, predicted %02h", cmd, want.cmd));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = 2'd0;
   logic [23:0] req_duration = 24'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_address;
   logic [7:0]  rsp_command;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = 3'd0;
   logic [23:0] csr_data = 24'd0;

   frame_scoreboard sb;
   ir_sample_type   plan[$];
   int unsigned     items_sent = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   logic            hold_on = 1'b0;
   event            hold_trig;

   nec_ir_frame_decoder_core #(
      .MAX_ELEMENTS(MAX_ELEMENTS),
      .DURATION_WIDTH(24)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_duration(req_duration),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind),
      .rsp_address(rsp_address),
      .rsp_command(rsp_command),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_frame(rsp_result_kind, rsp_address, rsp_command);
      rsp_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
   end

   initial forever begin
      @(hold_trig);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   initial begin
      #1000000;
      $display("tb: errors");
      $finish;
   end

   function automatic logic [23:0] pick_len(longint e, longint tol, int bad_pct);
      longint base, dev, d;
      base = (e == 0) ? 1 : e;
      dev = tol * base / 100;
      if ($urandom_range(99) < bad_pct) begin
         if ($urandom_range(1))
            d = e + dev + 1 + $urandom_range(2000);
         else
            d = e - dev - 1 - $urandom_range(2000);
      end else begin
         case ($urandom_range(9))
            0:       d = e + dev;
            1:       d = e - dev;
            default: d = e - dev + $urandom_range(32'(2 * dev));
         endcase
      end
      if (d < 0)
         d = 0;
      if (d > 64'hFFFFFF)
         d = 64'hFFFFFF;
      return d[23:0];
   endfunction

   task add_sample(sample_kind_type k, logic [23:0] d);
      ir_sample_type s;
      s.kind = k;
      s.dur = d;
      plan.insert(plan.size(), s);
   endtask

   task send_request(ir_sample_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= s.kind;
      req_duration <= s.dur;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_sample(s);
      items_sent++;
   endtask

   task run_plan();
      foreach (plan[j])
         send_request(plan[j]);
      plan.delete();
   endtask

   task wait_quiet();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_reg(csr_index_type idx, logic [23:0] val);
      logic [23:0] junk, data;
      junk = 24'($urandom);
      case (idx)
         CSR_END_SPACE:             data = val;
         CSR_LEAD_TOL, CSR_BIT_TOL: data = {junk[23:7], val[6:0]};
         default:                   data = {junk[23:16], val[15:0]};
      endcase
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   task configure(logic [15:0] hm, logic [15:0] hs, logic [15:0] rs, logic [15:0] un,
                  logic [15:0] one, logic [6:0] lt, logic [6:0] bt, logic [23:0] el);
      write_reg(CSR_HEADER_MARK, hm);
      write_reg(CSR_HEADER_SPACE, hs);
      write_reg(CSR_REPEAT_SPACE, rs);
      write_reg(CSR_UNIT, un);
      write_reg(CSR_ONE_SPACE, one);
      write_reg(CSR_LEAD_TOL, lt);
      write_reg(CSR_BIT_TOL, bt);
      write_reg(CSR_END_SPACE, el);
      csr_valid <= 1'b0;
   endtask

   task plan_end();
      longint d;
      if ($urandom_range(1)) begin
         add_sample(KIND_TIMEOUT, 24'($urandom));
      end else begin
         d = sb.end_len + $urandom_range(100);
         if (d > 64'hFFFFFF)
            d = 64'hFFFFFF;
         add_sample(KIND_SPACE, d[23:0]);
      end
   endtask

   task plan_full(int bad_pct, int cut, bit corrupt);
      logic [7:0]  addr, cmd;
      logic [31:0] data;
      logic [23:0] d;
      addr = 8'($urandom);
      cmd = 8'($urandom);
      data = {~cmd, cmd, ~addr, addr};
      if (corrupt)
         data = data ^ (32'h1 << $urandom_range(31));
      for (int i = 0; i < cut; i++) begin
         if (i == 0)
            d = pick_len(sb.hdr_mark, sb.lead_tol, bad_pct);
         else if (i == 1)
            d = pick_len(sb.hdr_space, sb.lead_tol, bad_pct);
         else if (i % 2 == 0)
            d = pick_len(sb.unit_len, sb.bit_tol, bad_pct);
         else if (data[(i - 3) / 2])
            d = pick_len(sb.one_len, sb.bit_tol, bad_pct);
         else
            d = pick_len(sb.unit_len, sb.bit_tol, bad_pct);
         add_sample((i % 2 == 0) ? KIND_MARK : KIND_SPACE, d);
      end
   endtask

   task plan_repeat(int bad_pct);
      add_sample(KIND_MARK, pick_len(sb.hdr_mark, sb.lead_tol, bad_pct));
      add_sample(KIND_SPACE, pick_len(sb.rpt_space, sb.lead_tol, bad_pct));
      add_sample(KIND_MARK, pick_len(sb.unit_len, sb.bit_tol, bad_pct));
      plan_end();
   endtask

   task plan_overflow();
      int n;
      n = MAX_ELEMENTS + $urandom_range(1, 8);
      add_sample(KIND_MARK, pick_len(sb.hdr_mark, sb.lead_tol, 0));
      for (int i = 1; i < n; i++)
         add_sample((i % 2 == 0) ? KIND_MARK : KIND_SPACE, pick_len(sb.unit_len, sb.bit_tol, 0));
      plan_end();
   endtask

   task plan_noise();
      int n;
      n = $urandom_range(1, 8);
      repeat (n)
         add_sample(sample_kind_type'($urandom_range(3)),
                    $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(20000)));
   endtask

   task plan_broken();
      int k;
      k = $urandom_range(1, 66);
      plan_full(0, k, 1'b0);
      case ($urandom_range(2))
         0: begin
            add_sample((k % 2 == 0) ? KIND_SPACE : KIND_MARK, sb.unit_len);
            plan_repeat(0);
         end
         1: plan_end();
         default: begin
            plan_full(0, FULL_LEN, 1'b0);
            plan_end();
         end
      endcase
   endtask

   task plan_directed();
      add_sample(KIND_OTHER, 24'hFFFFFF);
      add_sample(KIND_TIMEOUT, 24'h000000);
      add_sample(KIND_SPACE, 24'hFFFFFF);
      add_sample(KIND_MARK, HEADER_MARK_RESET);
      add_sample(KIND_SPACE, REPEAT_SPACE_RESET);
      add_sample(KIND_MARK, UNIT_RESET);
      add_sample(KIND_TIMEOUT, 24'hFFFFFF);
      add_sample(KIND_SPACE, UNIT_RESET);
      add_sample(KIND_MARK, HEADER_MARK_RESET);
      add_sample(KIND_MARK, HEADER_MARK_RESET);
      add_sample(KIND_SPACE, REPEAT_SPACE_RESET);
      add_sample(KIND_MARK, UNIT_RESET);
      add_sample(KIND_SPACE, END_SPACE_RESET);
      add_sample(KIND_MARK, 24'h000000);
      add_sample(KIND_OTHER, 24'h000000);
      add_sample(KIND_TIMEOUT, 24'h000000);
      add_sample(KIND_MARK, 24'hFFFFFF);
      add_sample(KIND_SPACE, 24'h000000);
      add_sample(KIND_SPACE, 24'(END_SPACE_RESET - 1));
      add_sample(KIND_TIMEOUT, 24'h000000);
      run_plan();
   endtask

   task random_step();
      int r;
      r = $urandom_range(99);
      if (r < 40) begin
         plan_full(($urandom_range(9) < 7) ? 0 : 2, FULL_LEN, $urandom_range(9) == 0);
         plan_end();
      end else if (r < 65) begin
         plan_repeat(($urandom_range(9) < 8) ? 0 : 10);
      end else if (r < 82) begin
         plan_broken();
      end else begin
         plan_noise();
      end
      run_plan();
   endtask

   task run_phase(int p, int unsigned quota);
      int unsigned item_mark;
      logic [15:0] hm, un;
      send_idle_pct = (p < 2) ? 38 : (p < 4) ? 83 : 0;
      recv_idle_pct = (p < 2) ? 83 : (p < 4) ? 38 : 0;
      if (p > 0)
         wait_quiet();
      case (p)
         1: begin
            hm = 16'($urandom_range(4000, 12000));
            un = 16'($urandom_range(300, 800));
            configure(hm, hm / 2, hm / 4, un, un * 3, 7'($urandom_range(10, 60)),
                      7'($urandom_range(10, 60)), 24'($urandom_range(20000, 100000)));
         end
         2: configure(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 7'd0, 7'd0, 24'hFFFFFF);
         3: configure(16'd9000, 16'd4500, 16'd2250, 16'd500, 16'd600, 7'd127, 7'd127,
                      24'd30000);
         4: configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 7'd0, 24'd1);
         5: configure(HEADER_MARK_RESET, HEADER_SPACE_RESET, REPEAT_SPACE_RESET, UNIT_RESET,
                      ONE_SPACE_RESET, LEAD_TOL_RESET, BIT_TOL_RESET, END_SPACE_RESET);
         default: ;
      endcase
      if (p == 0)
         plan_directed();
      if (p == 1) begin
         plan_overflow();
         run_plan();
      end
      if (p == 5) begin
         -> hold_trig;
         repeat (40)
            plan_repeat(0);
         run_plan();
      end
      item_mark = items_sent;
      while (items_sent - item_mark < quota)
         random_step();
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 6; p++)
         run_phase(p, 110);
      wait_quiet();
      if (sb.errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
